@@ hw/rtl/rdf_pkg.sv @@
// shared types, stream codes and the crc step of the readout event deframer
// no dependencies; imported by every rdf_* module and the top level

package rdf_pkg;

    // parse phases of one event
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_HEADER,
        PH_SEEK,
        PH_ANA_COUNT,
        PH_ANA_DATA,
        PH_ANA_CLOSE,
        PH_FRAME,
        PH_RECORD,
        PH_CRC_HI,
        PH_CRC_LO
    } phase_t;

    // error codes reported with each result word
    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_HEADER,
        ERR_ID,
        ERR_RECORDS,
        ERR_INCOMPLETE,
        ERR_ASICS
    } err_t;

    // one result word
    typedef struct packed {
        logic [7:0]  byte_out;
        logic        kept;
        logic        done;
        logic        ok;
        err_t        err;
        logic [15:0] length;
    } rdf_result_t;

    // stream marker bytes
    localparam logic [7:0] HDR_SHORT   = 8'hB0;
    localparam logic [7:0] HDR_LONG    = 8'hBB;
    localparam logic [7:0] ANA_START   = 8'hC4;
    localparam logic [7:0] FRAME_START = 8'hB4;
    localparam logic [7:0] FRAME_END   = 8'hA3;
    localparam logic [7:0] FRAME_BAD   = 8'hC3;
    localparam logic [7:0] EVENT_END   = 8'hA0;

    // header and record sizes
    localparam logic [5:0] HDR_LEN_SHORT  = 6'd23;
    localparam logic [5:0] HDR_LEN_LONG   = 6'd32;
    localparam logic [5:0] LINE_FIELD_IDX = 6'd22;
    localparam logic [5:0] RECORD_BODY    = 6'd19;

    // capacity limits
    localparam logic [7:0] MEM_DEPTH  = 8'd128;
    localparam logic [6:0] MAX_ASICS  = 7'd48;
    localparam logic [6:0] ASIC_LIMIT = MAX_ASICS + 7'd1;

    // crc-16/ccitt, msb first
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // apb register map
    localparam int          ADDR_W       = 3;
    localparam logic        REG_BOARD_ID = 1'b0;
    localparam logic [15:0] LEN_MAX      = 16'hFFFF;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] din);
        logic [15:0] c;
        c = crc ^ {din, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/readout_event_deframer.sv @@
// word path: an accepted word is held in the input register, then passes through the parser
//   into the result register once the result register is free
// throughput: one word per cycle while the result register is free; the parse step between
//   the input register and the result register is a single crc byte step and a phase update
// reset: rst_n is asynchronous, active low; board_id clears to 0, the parser
//   goes idle with crc 0xFFFF and both word registers empty
// top level of the readout event deframer; depends on rdf_pkg, rdf_apb_regs,
//   rdf_in_stage, rdf_parser and rdf_out_stage

module readout_event_deframer
    import rdf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // stream word in
    input  logic              data_valid,
    output logic              data_ready,
    input  logic [7:0]        data_byte,
    // result word out
    output logic              result_valid,
    input  logic              result_ready,
    output logic [7:0]        byte_out,
    output logic              byte_kept,
    output logic              event_done,
    output logic              crc_ok,
    output logic [2:0]        error_code,
    output logic [15:0]       event_length
);

    logic [7:0]  board_id;
    logic        held_valid;
    logic [7:0]  held_byte;
    logic        out_free;
    logic        step;
    rdf_result_t parse_res;
    rdf_result_t res_out;

    // the parser advances whenever a word is held and the result slot frees up
    assign step = held_valid && out_free;

    // board id register
    rdf_apb_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .board_id (board_id)
    );

    // input word register
    rdf_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_ready (data_ready),
        .data_byte  (data_byte),
        .advance    (step),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    // phase machine, counters and running crc
    rdf_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .b        (held_byte),
        .board_id (board_id),
        .res      (parse_res)
    );

    // result word register
    rdf_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (step),
        .res_in       (parse_res),
        .free         (out_free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .res_out      (res_out)
    );

    // unpack the result word onto the ports
    assign byte_out     = res_out.byte_out;
    assign byte_kept    = res_out.kept;
    assign event_done   = res_out.done;
    assign crc_ok       = res_out.ok;
    assign error_code   = res_out.err;
    assign event_length = res_out.length;

endmodule

@@ hw/rtl/rdf_apb_regs.sv @@
// apb configuration register of the deframer (board id)
// depends on rdf_pkg for the address width and register index

module rdf_apb_regs
    import rdf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [7:0]        board_id
);

    logic [7:0] board_id_reg;
    logic [7:0] board_id_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_BOARD_ID);

    always_comb
    begin
        board_id_next = board_id_reg;
        if (wr_en)
        begin
            board_id_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_id_reg <= 8'd0;
        end
        else
        begin
            board_id_reg <= board_id_next;
        end
    end

    assign prdata   = (paddr[2] == REG_BOARD_ID) ? {24'd0, board_id_reg} : 32'd0;
    assign board_id = board_id_reg;

endmodule

@@ hw/rtl/rdf_in_stage.sv @@
// input register of the deframer: holds one accepted stream word
// depends on rdf_pkg (no items used beyond the common import)

module rdf_in_stage
    import rdf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       data_valid,
    output logic       data_ready,
    input  logic [7:0] data_byte,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       load;

    assign data_ready = !valid_reg || advance;
    assign load       = data_valid && data_ready;

    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        if (load)
        begin
            valid_next = 1'b1;
            byte_next  = data_byte;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

@@ hw/rtl/rdf_parser.sv @@
// event parse state, running crc and per-word result decode
// depends on rdf_pkg for phases, error codes, markers and crc16_byte

module rdf_parser
    import rdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  b,
    input  logic [7:0]  board_id,
    output rdf_result_t res
);

    phase_t      phase_reg,        phase_next;
    logic [15:0] crc_reg,          crc_next;
    logic        long_header_reg,  long_header_next;
    logic [5:0]  byte_count_reg,   byte_count_next;
    logic [3:0]  line_total_reg,   line_total_next;
    logic [3:0]  line_index_reg,   line_index_next;
    logic [14:0] analog_left_reg,  analog_left_next;
    logic [7:0]  record_count_reg, record_count_next;
    logic [6:0]  asic_count_reg,   asic_count_next;
    logic [7:0]  crc_high_reg,     crc_high_next;
    logic [15:0] length_count_reg, length_count_next;

    err_t        err;
    logic        done;
    logic [5:0]  bc_inc;
    logic [3:0]  line_inc;
    logic [14:0] analog_dec;
    logic [15:0] len_inc;
    logic        feed;

    assign bc_inc     = byte_count_reg + 6'd1;
    assign line_inc   = line_index_reg + 4'd1;
    assign analog_dec = analog_left_reg - 15'd1;
    assign len_inc    = (length_count_reg != LEN_MAX) ? length_count_reg + 16'd1
                                                      : length_count_reg;

    // error decode
    always_comb
    begin
        err  = ERR_NONE;
        done = (phase_reg == PH_CRC_LO);
        case (phase_reg)
            PH_IDLE:
            begin
                if (!(b == HDR_SHORT || b == HDR_LONG))
                begin
                    err = ERR_HEADER;
                end
            end
            PH_HEADER:
            begin
                if (byte_count_reg == 6'd0 && b != board_id)
                begin
                    err = ERR_ID;
                end
            end
            PH_FRAME:
            begin
                if (b == FRAME_BAD)
                begin
                    err = ERR_INCOMPLETE;
                end
                else if (b == FRAME_END && asic_count_reg >= ASIC_LIMIT)
                begin
                    err = ERR_ASICS;
                end
            end
            PH_RECORD:
            begin
                if (bc_inc >= RECORD_BODY && record_count_reg >= MEM_DEPTH)
                begin
                    err = ERR_RECORDS;
                end
            end
            PH_SEEK, PH_ANA_COUNT, PH_ANA_DATA, PH_ANA_CLOSE, PH_CRC_HI, PH_CRC_LO:
            begin
                err = ERR_NONE;
            end
            default:
            begin
                err = ERR_HEADER;
            end
        endcase
    end

    // next state
    always_comb
    begin
        phase_next        = phase_reg;
        crc_next          = crc_reg;
        long_header_next  = long_header_reg;
        byte_count_next   = byte_count_reg;
        line_total_next   = line_total_reg;
        line_index_next   = line_index_reg;
        analog_left_next  = analog_left_reg;
        record_count_next = record_count_reg;
        asic_count_next   = asic_count_reg;
        crc_high_next     = crc_high_reg;
        length_count_next = len_inc;
        feed              = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                feed             = 1'b1;
                long_header_next = (b == HDR_LONG);
                byte_count_next  = 6'd0;
                phase_next       = PH_HEADER;
            end
            PH_HEADER:
            begin
                feed            = 1'b1;
                byte_count_next = bc_inc;
                if (byte_count_reg == LINE_FIELD_IDX)
                begin
                    line_total_next = b[7:4];
                end
                if (bc_inc >= (long_header_reg ? HDR_LEN_LONG : HDR_LEN_SHORT))
                begin
                    phase_next = PH_SEEK;
                end
            end
            PH_SEEK:
            begin
                if (b == ANA_START)
                begin
                    line_index_next = 4'd0;
                    phase_next = (line_total_reg == 4'd0) ? PH_ANA_CLOSE : PH_ANA_COUNT;
                end
                else if (b == FRAME_START)
                begin
                    feed              = 1'b1;
                    record_count_next = 8'd0;
                    phase_next        = PH_FRAME;
                end
                else if (b == EVENT_END)
                begin
                    phase_next = PH_CRC_HI;
                end
            end
            PH_ANA_COUNT:
            begin
                // count byte times 128 data bytes
                analog_left_next = {b, 7'd0};
                if (b == 8'd0)
                begin
                    line_index_next = line_inc;
                    phase_next = (line_inc == line_total_reg) ? PH_ANA_CLOSE : PH_ANA_COUNT;
                end
                else
                begin
                    phase_next = PH_ANA_DATA;
                end
            end
            PH_ANA_DATA:
            begin
                analog_left_next = analog_dec;
                if (analog_dec == 15'd0)
                begin
                    line_index_next = line_inc;
                    phase_next = (line_inc == line_total_reg) ? PH_ANA_CLOSE : PH_ANA_COUNT;
                end
            end
            PH_ANA_CLOSE:
            begin
                phase_next = PH_SEEK;
            end
            PH_FRAME:
            begin
                feed = 1'b1;
                if (b == FRAME_END)
                begin
                    record_count_next = 8'd0;
                    asic_count_next   = asic_count_reg + 7'd1;
                    phase_next        = PH_SEEK;
                end
                else
                begin
                    byte_count_next = 6'd0;
                    phase_next      = PH_RECORD;
                end
            end
            PH_RECORD:
            begin
                feed            = 1'b1;
                byte_count_next = bc_inc;
                if (bc_inc >= RECORD_BODY)
                begin
                    record_count_next = record_count_reg + 8'd1;
                    phase_next        = PH_FRAME;
                end
            end
            PH_CRC_HI:
            begin
                crc_high_next = b;
                phase_next    = PH_CRC_LO;
            end
            PH_CRC_LO:
            begin
                phase_next = PH_CRC_LO;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (feed)
        begin
            crc_next = crc16_byte(crc_reg, b);
        end

        // error or event end: back to a clean idle
        if (err != ERR_NONE || done)
        begin
            phase_next        = PH_IDLE;
            crc_next          = CRC_INIT;
            long_header_next  = 1'b0;
            byte_count_next   = 6'd0;
            line_total_next   = 4'd0;
            line_index_next   = 4'd0;
            analog_left_next  = 15'd0;
            record_count_next = 8'd0;
            asic_count_next   = 7'd0;
            crc_high_next     = 8'd0;
            length_count_next = 16'd0;
        end
    end

    // result word
    always_comb
    begin
        res.byte_out = b;
        res.kept     = (err == ERR_NONE);
        res.done     = done;
        res.ok       = done && ({crc_high_reg, b} == crc_reg);
        res.err      = err;
        res.length   = (err == ERR_NONE) ? len_inc : length_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            crc_reg          <= CRC_INIT;
            long_header_reg  <= 1'b0;
            byte_count_reg   <= 6'd0;
            line_total_reg   <= 4'd0;
            line_index_reg   <= 4'd0;
            analog_left_reg  <= 15'd0;
            record_count_reg <= 8'd0;
            asic_count_reg   <= 7'd0;
            crc_high_reg     <= 8'd0;
            length_count_reg <= 16'd0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            crc_reg          <= crc_next;
            long_header_reg  <= long_header_next;
            byte_count_reg   <= byte_count_next;
            line_total_reg   <= line_total_next;
            line_index_reg   <= line_index_next;
            analog_left_reg  <= analog_left_next;
            record_count_reg <= record_count_next;
            asic_count_reg   <= asic_count_next;
            crc_high_reg     <= crc_high_next;
            length_count_reg <= length_count_next;
        end
    end

`ifndef SYNTH
    a_err_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && err != ERR_NONE |=> phase_reg == PH_IDLE && crc_reg == CRC_INIT)
        else $error("parser not idle after error");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_CRC_LO |=> phase_reg == PH_IDLE && length_count_reg == 16'd0)
        else $error("event state not cleared after crc");

    a_start_header: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_IDLE && err == ERR_NONE
        |=> phase_reg == PH_HEADER && byte_count_reg == 6'd0 && length_count_reg == 16'd1)
        else $error("global header did not open an event");

    a_ok_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        res.ok |-> res.done && res.kept)
        else $error("crc_ok without event end");
`endif

endmodule

@@ hw/rtl/rdf_out_stage.sv @@
// result register of the deframer, decouples the parser from the sink
// depends on rdf_pkg for the result word type

module rdf_out_stage
    import rdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  rdf_result_t res_in,
    output logic        free,
    output logic        result_valid,
    input  logic        result_ready,
    output rdf_result_t res_out
);

    logic        valid_reg;
    logic        valid_next;
    rdf_result_t res_reg;
    rdf_result_t res_next;

    assign free = !valid_reg || result_ready;

    always_comb
    begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (load)
        begin
            valid_next = 1'b1;
            res_next   = res_in;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result_valid = valid_reg;
    assign res_out      = res_reg;

endmodule

@@ tb/rdf_deframe_checker.sv @@
// scoreboard of the readout event deframer: watches the config port and both word channels,
// predicts every result word from the accepted stream words and compares it field by field
// depends on rdf_pkg

module rdf_deframe_checker
    import rdf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    input  logic              data_valid,
    input  logic              data_ready,
    input  logic [7:0]        data_byte,
    input  logic              result_valid,
    input  logic              result_ready,
    input  logic [7:0]        byte_out,
    input  logic              byte_kept,
    input  logic              event_done,
    input  logic              crc_ok,
    input  logic [2:0]        error_code,
    input  logic [15:0]       event_length,
    output int                fail_count,
    output int                words_pending
);

    localparam logic [ADDR_W-1:0] BOARD_ID_ADDR = ADDR_W'(4 * REG_BOARD_ID);

    // predicted parser state
    logic [7:0]  board_id;
    phase_t      phase;
    logic [15:0] crc;
    logic        long_hdr;
    logic [5:0]  hdr_cnt;
    logic [3:0]  lines;
    logic [3:0]  line_idx;
    logic [14:0] ana_left;
    logic [7:0]  rec_cnt;
    logic [6:0]  asic_cnt;
    logic [7:0]  crc_hi;
    logic [15:0] kept_len;

    rdf_result_t deframed_q[$];
    rdf_result_t predicted;
    rdf_result_t oldest;

    function automatic logic [15:0] crc_advance(input logic [15:0] acc, input logic [7:0] value);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int k = 7; k >= 0; k--)
        begin
            fb = c[15] ^ value[k];
            c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    task automatic drop_event();
        phase = PH_IDLE;
        crc = CRC_INIT;
        long_hdr = 1'b0;
        hdr_cnt = '0;
        lines = '0;
        line_idx = '0;
        ana_left = '0;
        rec_cnt = '0;
        asic_cnt = '0;
        crc_hi = '0;
        kept_len = '0;
    endtask

    task automatic next_line();
        line_idx = line_idx + 4'd1;
        phase = (line_idx == lines) ? PH_ANA_CLOSE : PH_ANA_COUNT;
    endtask

    task automatic deframe_step(input logic [7:0] b, output rdf_result_t r);
        logic        kept;
        logic        done;
        logic        ok;
        err_t        fault;
        logic [15:0] prev_len;
        logic [5:0]  hdr_len;
        kept = 1'b1;
        done = 1'b0;
        ok = 1'b0;
        fault = ERR_NONE;
        prev_len = kept_len;
        hdr_len = long_hdr ? HDR_LEN_LONG : HDR_LEN_SHORT;
        case (phase)
            PH_IDLE:
            begin
                if (b == HDR_SHORT || b == HDR_LONG)
                begin
                    crc = crc_advance(crc, b);
                    long_hdr = (b == HDR_LONG);
                    hdr_cnt = '0;
                    phase = PH_HEADER;
                end
                else
                begin
                    fault = ERR_HEADER;
                end
            end
            PH_HEADER:
            begin
                if (hdr_cnt == 6'd0 && b != board_id)
                begin
                    fault = ERR_ID;
                end
                else
                begin
                    crc = crc_advance(crc, b);
                    if (hdr_cnt == LINE_FIELD_IDX)
                        lines = b[7:4];
                    hdr_cnt = hdr_cnt + 6'd1;
                    if (hdr_cnt >= hdr_len)
                        phase = PH_SEEK;
                end
            end
            PH_SEEK:
            begin
                if (b == ANA_START)
                begin
                    line_idx = '0;
                    phase = (lines == 4'd0) ? PH_ANA_CLOSE : PH_ANA_COUNT;
                end
                else if (b == FRAME_START)
                begin
                    crc = crc_advance(crc, b);
                    rec_cnt = '0;
                    phase = PH_FRAME;
                end
                else if (b == EVENT_END)
                begin
                    phase = PH_CRC_HI;
                end
            end
            PH_ANA_COUNT:
            begin
                ana_left = {b, 7'd0};
                if (ana_left == '0)
                    next_line();
                else
                    phase = PH_ANA_DATA;
            end
            PH_ANA_DATA:
            begin
                ana_left = ana_left - 15'd1;
                if (ana_left == '0)
                    next_line();
            end
            PH_ANA_CLOSE:
            begin
                phase = PH_SEEK;
            end
            PH_FRAME:
            begin
                if (b == FRAME_BAD)
                begin
                    fault = ERR_INCOMPLETE;
                end
                else if (b == FRAME_END)
                begin
                    if (asic_cnt >= ASIC_LIMIT)
                    begin
                        fault = ERR_ASICS;
                    end
                    else
                    begin
                        crc = crc_advance(crc, b);
                        rec_cnt = '0;
                        asic_cnt = asic_cnt + 7'd1;
                        phase = PH_SEEK;
                    end
                end
                else
                begin
                    crc = crc_advance(crc, b);
                    hdr_cnt = '0;
                    phase = PH_RECORD;
                end
            end
            PH_RECORD:
            begin
                hdr_cnt = hdr_cnt + 6'd1;
                if (hdr_cnt >= RECORD_BODY)
                begin
                    if (rec_cnt >= MEM_DEPTH)
                    begin
                        fault = ERR_RECORDS;
                    end
                    else
                    begin
                        rec_cnt = rec_cnt + 8'd1;
                        phase = PH_FRAME;
                    end
                end
                if (fault == ERR_NONE)
                    crc = crc_advance(crc, b);
            end
            PH_CRC_HI:
            begin
                crc_hi = b;
                phase = PH_CRC_LO;
            end
            PH_CRC_LO:
            begin
                done = 1'b1;
                ok = ({crc_hi, b} == crc);
            end
            default:
            begin
                fault = ERR_HEADER;
            end
        endcase

        if (fault != ERR_NONE || (phase == PH_IDLE && !done))
            kept = 1'b0;
        if (kept && kept_len != LEN_MAX)
            kept_len = kept_len + 16'd1;

        r.byte_out = b;
        r.kept = kept;
        r.done = done;
        r.ok = done && ok;
        r.err = fault;
        r.length = (fault != ERR_NONE) ? prev_len : kept_len;

        if (fault != ERR_NONE || done)
            drop_event();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_id = 8'h00;
            drop_event();
            deframed_q.delete();
            fail_count = 0;
            words_pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == BOARD_ID_ADDR)
                board_id = pwdata[7:0];
            if (data_valid && data_ready)
            begin
                deframe_step(data_byte, predicted);
                deframed_q.push_back(predicted);
            end
            if (result_valid && result_ready)
            begin
                if (deframed_q.size() == 0)
                begin
                    $error("result word with nothing expected: byte_out %0h", byte_out);
                    fail_count++;
                end
                else
                begin
                    oldest = deframed_q.pop_front();
                    if (byte_out !== oldest.byte_out)
                    begin
                        $error("byte_out: expected %0h, got %0h", oldest.byte_out, byte_out);
                        fail_count++;
                    end
                    if (byte_kept !== oldest.kept)
                    begin
                        $error("byte_kept: expected %0b, got %0b", oldest.kept, byte_kept);
                        fail_count++;
                    end
                    if (event_done !== oldest.done)
                    begin
                        $error("event_done: expected %0b, got %0b", oldest.done, event_done);
                        fail_count++;
                    end
                    if (crc_ok !== oldest.ok)
                    begin
                        $error("crc_ok: expected %0b, got %0b", oldest.ok, crc_ok);
                        fail_count++;
                    end
                    if (error_code !== oldest.err)
                    begin
                        $error("error_code: expected %0d, got %0d", oldest.err, error_code);
                        fail_count++;
                    end
                    if (event_length !== oldest.length)
                    begin
                        $error("event_length: expected %0d, got %0d", oldest.length,
                               event_length);
                        fail_count++;
                    end
                end
            end
            words_pending <= deframed_q.size();
        end
    end

endmodule

@@ tb/tb.sv @@
// top of the readout event deframer testbench: clock, reset, board id writes, framed stream
// stimulus with random gaps and back-pressure, watchdog and verdict
// depends on rdf_pkg, readout_event_deframer and rdf_deframe_checker

module tb;
    import rdf_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int PHASE_WORDS    = 100;
    localparam int PHASES         = 5;
    localparam logic [ADDR_W-1:0] BOARD_ID_ADDR = ADDR_W'(4 * REG_BOARD_ID);

    // shapes of generated events
    typedef enum int {
        EV_RANDOM,
        EV_FRAMES_FULL,
        EV_FRAMES_OVER
    } event_kind_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              data_valid;
    logic              data_ready;
    logic [7:0]        data_byte;
    logic              result_valid;
    logic              result_ready = 1'b0;
    logic [7:0]        byte_out;
    logic              byte_kept;
    logic              event_done;
    logic              crc_ok;
    logic [2:0]        error_code;
    logic [15:0]       event_length;
    int                fail_count;
    int                words_pending;

    // stream under construction and the crc the generator runs alongside it
    logic [7:0]  stream_q[$];
    logic [15:0] gen_crc;
    logic [7:0]  cur_id;
    logic        steady = 1'b0;
    int          stall_left = 0;
    int          idle_cycles = 0;
    int          items_sent = 0;
    int          target;

    always #5 clk = ~clk;

    readout_event_deframer dut (.*);

    rdf_deframe_checker deframe_chk (.*);

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 50);
    endfunction

    function automatic logic [15:0] crc_after(input logic [15:0] acc, input logic [7:0] value);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int k = 7; k >= 0; k--)
        begin
            fb = c[15] ^ value[k];
            c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    // receiver back-pressure: stalls of random length, none while steady
    always @(posedge clk)
    begin
        if (steady)
        begin
            stall_left <= 0;
            result_ready <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // watchdog: counts cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (data_valid && data_ready) || (result_valid && result_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // append one byte; covered bytes go into the generator crc
    task automatic put(input logic [7:0] value, input bit covered);
        stream_q.push_back(value);
        if (covered)
            gen_crc = crc_after(gen_crc, value);
    endtask

    // global header marker, board id and the rest of the header; byte 22 carries the lines
    task automatic add_header(input bit long_form, input logic [7:0] id, input logic [3:0] lines);
        gen_crc = CRC_INIT;
        put(long_form ? HDR_LONG : HDR_SHORT, 1'b1);
        put(id, 1'b1);
        for (int i = 1; i < (long_form ? HDR_LEN_LONG : HDR_LEN_SHORT); i++)
        begin
            if (i == LINE_FIELD_IDX)
                put({lines, 4'($urandom)}, 1'b1);
            else
                put(8'($urandom), 1'b1);
        end
    endtask

    // digital frame; with cut, an incomplete-frame marker replaces one record header or the
    // trailer
    task automatic add_frame(input int records, input bit cut);
        int         cut_at;
        logic [7:0] head;
        cut_at = cut ? $urandom_range(0, records) : -1;
        put(FRAME_START, 1'b1);
        for (int k = 0; k < records; k++)
        begin
            if (k == cut_at)
            begin
                put(FRAME_BAD, 1'b0);
                return;
            end
            head = 8'($urandom);
            while (head == FRAME_BAD || head == FRAME_END)
                head = 8'($urandom);
            put(head, 1'b1);
            repeat (RECORD_BODY) put(8'($urandom), 1'b1);
        end
        put(cut ? FRAME_BAD : FRAME_END, !cut);
    endtask

    // event end marker and big-endian crc, optionally damaged
    task automatic add_trailer(input bit corrupt);
        logic [15:0] sent_crc;
        sent_crc = gen_crc ^ (corrupt ? 16'($urandom_range(1, 65535)) : 16'h0000);
        put(EVENT_END, 1'b0);
        put(sent_crc[15:8], 1'b0);
        put(sent_crc[7:0], 1'b0);
    endtask

    task automatic build_event(input event_kind_t kind);
        bit         long_form;
        bit         cut;
        logic [3:0] lines;
        logic [7:0] count;
        logic [7:0] stray;
        int         pick;
        case (kind)
            EV_FRAMES_FULL:
            begin
                // every frame the asic limit allows, all empty
                add_header(1'b1, cur_id, 4'd0);
                repeat (ASIC_LIMIT) add_frame(0, 1'b0);
                add_trailer(1'b0);
            end
            EV_FRAMES_OVER:
            begin
                // one frame past the asic limit: error on its trailer
                add_header(1'b1, cur_id, 4'd0);
                repeat (ASIC_LIMIT + 1) add_frame(0, 1'b0);
            end
            default:
            begin
                long_form = $urandom_range(0, 1);
                if ($urandom_range(0, 11) == 0)
                begin
                    // wrong board id: the event dies on header byte 0
                    put(long_form ? HDR_LONG : HDR_SHORT, 1'b1);
                    put(cur_id ^ 8'($urandom_range(1, 255)), 1'b1);
                    return;
                end
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    lines = 4'd0;
                else if (pick < 85)
                    lines = 4'($urandom_range(1, 2));
                else
                    lines = 4'($urandom_range(3, 15));
                add_header(long_form, cur_id, lines);
                repeat ($urandom_range(0, 4))
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 30)
                    begin
                        // analog block: count byte and count*128 samples per line, then the
                        // closing byte; none of it in the crc
                        put(ANA_START, 1'b0);
                        for (int l = 0; l < lines; l++)
                        begin
                            pick = $urandom_range(0, 99);
                            if (lines > 4'd2 || pick < 50)
                                count = 8'd0;
                            else if (pick < 95)
                                count = 8'd1;
                            else
                                count = 8'd2;
                            put(count, 1'b0);
                            repeat (count * 128) put(8'($urandom), 1'b0);
                        end
                        put(8'($urandom), 1'b0);
                    end
                    else if (pick < 80)
                    begin
                        cut = ($urandom_range(0, 19) == 0);
                        add_frame($urandom_range(0, 3), cut);
                        if (cut)
                            return;
                    end
                    else
                    begin
                        // stray byte between blocks: kept but ignored
                        stray = 8'($urandom);
                        while (stray == ANA_START || stray == FRAME_START || stray == EVENT_END)
                            stray = 8'($urandom);
                        put(stray, 1'b0);
                    end
                end
                add_trailer($urandom_range(0, 4) == 0);
            end
        endcase
    endtask

    // offer one word, after a random gap unless steady, and hold it until taken
    task automatic push_byte(input logic [7:0] value);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap != 0)
        begin
            data_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        data_valid <= 1'b1;
        data_byte <= value;
        @(posedge clk);
        while (!data_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_stream();
        while (stream_q.size() != 0)
            push_byte(stream_q.pop_front());
    endtask

    // sender pauses until every predicted word has come out, then lets the pipe settle
    task automatic drain_results();
        data_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write of the board id: setup cycle, then access cycle
    task automatic write_board_id(input logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= BOARD_ID_ADDR;
        pwdata <= {24'h000000, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_id = value;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        data_valid <= 1'b0;
        data_byte <= 8'h00;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: bytes in idle that open no event, a wrong id on a long header,
        // then one bare event with no blocks and a good crc
        write_board_id(8'h00);
        put(8'h00, 1'b0);
        put(8'hFF, 1'b0);
        put(HDR_LONG, 1'b0);
        put(8'hFF, 1'b0);
        add_header(1'b0, cur_id, 4'd0);
        add_trailer(1'b0);
        send_stream();

        // random phases, each under its own board id; two open with a many-frame event
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            case (ph)
                0: write_board_id(8'hFF);
                1: write_board_id(8'($urandom));
                2: write_board_id(HDR_SHORT);
                3: write_board_id(8'h00);
                default: write_board_id(8'($urandom));
            endcase
            if (ph == 2)
                build_event(EV_FRAMES_FULL);
            else if (ph == 3)
                build_event(EV_FRAMES_OVER);
            send_stream();
            target = items_sent + PHASE_WORDS;
            while (items_sent < target)
            begin
                steady <= ($urandom_range(0, 5) == 0);
                // idle noise ahead of the event
                if ($urandom_range(0, 11) == 0)
                    repeat ($urandom_range(1, 3)) put(8'($urandom), 1'b0);
                build_event(EV_RANDOM);
                // now and then an event broken off early
                if ($urandom_range(0, 15) == 0 && stream_q.size() > 1)
                    repeat ($urandom_range(1, stream_q.size() - 1))
                        void'(stream_q.pop_back());
                send_stream();
                if ($urandom_range(0, 19) == 0)
                    drain_results();
            end
        end

        steady <= 1'b0;
        drain_results();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
